FILE: design/mlp_one_hidden_layer_trainer_top_macros.svh
// assertion helpers shared by the checker
`ifndef MLP_ONE_HIDDEN_LAYER_TRAINER_TOP_MACROS_SVH
`define MLP_ONE_HIDDEN_LAYER_TRAINER_TOP_MACROS_SVH

// clocked assertion, idle while reset is applied
`define MLPT_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// implication form on the same clock
`define MLPT_ASSERT_IMP(lbl, ante, cons, msg) \
    `MLPT_ASSERT(lbl, (ante) |-> (cons), msg)

`endif

FILE: design/mlpt_pkg.sv
`default_nettype none
package mlpt_pkg;

    localparam int MAX_INPUTS = 8;
    localparam int MAX_HIDDEN = 8;
    localparam int IDX_W = 6;
    localparam int CNT_W = 7;
    localparam int SIG_LOG = 8;
    localparam int ACC_W = 40;

    localparam logic [1:0] KIND_PRED  = 2'd0;
    localparam logic [1:0] KIND_TRAIN = 2'd1;
    localparam logic [1:0] KIND_LOAD  = 2'd2;

    localparam logic [1:0] CFG_LR = 2'd0;
    localparam logic [1:0] CFG_NI = 2'd1;
    localparam logic [1:0] CFG_NH = 2'd2;

    typedef enum logic [3:0] {
        CELL_NOP,
        CELL_CLR,
        CELL_LOAD,
        CELL_MAC,
        CELL_ACT,
        CELL_UPV,
        CELL_HERR,
        CELL_HDEL,
        CELL_LRH,
        CELL_UPW
    } cell_op_t;

    typedef struct packed {
        cell_op_t            op;
        logic [CNT_W-1:0]    ni;
        logic [CNT_W-1:0]    nh;
        logic [15:0]         lr;
        logic signed [11:0]  delta;
        logic signed [29:0]  lrd;
        logic                ld_v;
        logic [IDX_W-1:0]    ld_i;
        logic [IDX_W-1:0]    ld_j;
        logic signed [15:0]  ld_val;
    } cell_ctrl_t;

    typedef struct packed {
        logic               xv;
        logic [IDX_W-1:0]   idx;
        logic signed [15:0] x;
    } chain_t;

    function automatic logic signed [47:0] rnd_sh12(input logic signed [47:0] v);
        return (v + 48'sd2048) >>> 12;
    endfunction

    function automatic logic signed [47:0] rnd_sh28(input logic signed [47:0] v);
        return (v + 48'sd134217728) >>> 28;
    endfunction

    // {clipped flag, value}
    function automatic logic [16:0] clip_q(input logic signed [47:0] v);
        if (v > 48'sd32767)
            return {1'b1, 16'h7fff};
        else if (v < -48'sd32768)
            return {1'b1, 16'h8000};
        else
            return {1'b0, v[15:0]};
    endfunction

    function automatic logic [12:0] sigmoid_q(input logic signed [15:0] x);
        logic [15:0]        u;
        logic [SIG_LOG-1:0] cidx;
        logic [15:0]        cu;
        logic signed [16:0] c;
        logic [15:0]        a;
        logic [12:0]        y;
        u = {~x[15], x[14:0]};
        cidx = u[15 -: SIG_LOG];
        // center code of the cell
        cu = 16'({cidx, 1'b1}) << (15 - SIG_LOG);
        c = $signed({1'b0, cu}) - 17'sd32768;
        a = (c < 0) ? 16'(-c) : 16'(c);
        if (a >= 16'd20480)
            y = 13'd4096;
        else if (a >= 16'd9728)
            y = 13'(a >> 5) + 13'd3456;
        else if (a >= 16'd4096)
            y = 13'(a >> 3) + 13'd2560;
        else
            y = 13'(a >> 2) + 13'd2048;
        return (c < 0) ? 13'd4096 - y : y;
    endfunction

    function automatic logic [10:0] deriv_q(input logic [12:0] y);
        logic [25:0] p;
        p = 26'(y) * 26'(13'd4096 - y);
        return 11'(p >> 12);
    endfunction

endpackage
`default_nettype wire

FILE: design/mlp_one_hidden_layer_trainer_top.sv
// one-hidden-layer perceptron with online gradient step
// s_* stream: one item per transaction. s_tuser is the kind (predict feature,
// train feature, weight load), s_tlast marks the last feature of a sample.
// a weight load or a non-last feature is taken while the block stays idle. the last
// feature starts the sample: features walk the row of hidden-neuron cells, one cell
// per cycle, each cell doing its own multiply-accumulate, then come the sigmoid of
// the hidden cells, the output sum over the hidden neurons and one more sigmoid.
// train samples then add an update pass of the output and hidden weights.
// s_tready is low while a sample is being worked on.
// m_* stream carries one result per sample from an output register; the next
// sample's features are taken while the result waits, and a new result waits
// for a stalled receiver before it is loaded.
// cfg_* writes learning rate, inputs and hidden neurons in use; always ready.
// reset zeroes all weights and puts the configuration registers at their defaults.
`default_nettype none
module mlp_one_hidden_layer_trainer_top (
    input  wire         clk,
    input  wire         rst_n,
    input  wire         s_tvalid,
    output logic        s_tready,
    input  wire  [39:0] s_tdata,   // value[15:0], target[28:16], weight_index[35:29], zero
    input  wire  [1:0]  s_tuser,   // kind[1:0]
    input  wire         s_tlast,
    output logic        m_tvalid,
    input  wire         m_tready,
    output logic [15:0] m_tdata,   // prediction[12:0], was_training, saturated, overrun
    input  wire         cfg_valid,
    output logic        cfg_ready,
    input  wire  [1:0]  cfg_index,
    input  wire  [15:0] cfg_data
);
    import mlpt_pkg::*;

    localparam int IW = (MAX_INPUTS > 1) ? $clog2(MAX_INPUTS) : 1;
    localparam int JW = (MAX_HIDDEN > 1) ? $clog2(MAX_HIDDEN) : 1;
    localparam int CW = $clog2(MAX_INPUTS + 1);
    localparam int SW = $clog2(MAX_INPUTS + MAX_HIDDEN + 1);
    localparam int NUM_IW = MAX_INPUTS * MAX_HIDDEN;

    typedef enum logic [3:0] {
        S_IDLE, S_FWD, S_ACT, S_OSUM, S_OACT, S_DERO, S_DELTA, S_LRD,
        S_UPV, S_HERR, S_HDEL, S_LRH, S_UPW, S_DONE
    } state_t;

    state_t                  state_reg;
    logic [15:0]             lr_reg;
    logic [3:0]              ni_reg;
    logic [3:0]              nh_reg;
    logic signed [15:0]      buf_reg [MAX_INPUTS];
    logic [CW-1:0]           cnt_reg;
    logic                    ovr_reg;
    logic                    train_reg;
    logic [12:0]             target_reg;
    logic [SW-1:0]           step_reg;
    logic signed [ACC_W-1:0] acc_reg;
    logic [12:0]             o_reg;
    logic [10:0]             dero_reg;
    logic signed [11:0]      delta_reg;
    logic signed [29:0]      lrd_reg;
    logic                    osat_reg;
    logic                    m_tvalid_reg;
    logic [15:0]             m_tdata_reg;

    logic signed [15:0]      in_value;
    logic [12:0]             in_target;
    logic [12:0]             widx;
    logic                    s_acc;
    logic                    is_feat;
    logic [CNT_W-1:0]        ni_c;
    logic [CNT_W-1:0]        nh_c;
    logic                    ld_ok;
    cell_ctrl_t              ctrl;
    chain_t                  chain_w [MAX_HIDDEN];
    logic [12:0]             cell_h [MAX_HIDDEN];
    logic signed [15:0]      cell_v [MAX_HIDDEN];
    logic [MAX_HIDDEN-1:0]   cell_sat;
    logic signed [29:0]      osum_prod;
    logic [16:0]             o_clip;
    logic                    out_free;

    function automatic logic [CNT_W-1:0] clamp_cnt(input logic [3:0] v, input int mx);
        if (v == 4'd0)
            return CNT_W'(1);
        else if (int'(v) > mx)
            return CNT_W'(mx);
        else
            return CNT_W'(v);
    endfunction

    assign in_value  = $signed(s_tdata[15:0]);
    assign in_target = s_tdata[28:16];
    assign widx      = 13'(s_tdata[35:29]);
    assign s_tready  = state_reg == S_IDLE;
    assign cfg_ready = 1'b1;
    assign s_acc     = s_tvalid && s_tready;
    assign is_feat   = s_tuser == KIND_PRED || s_tuser == KIND_TRAIN;
    assign ni_c      = clamp_cnt(ni_reg, MAX_INPUTS);
    assign nh_c      = clamp_cnt(nh_reg, MAX_HIDDEN);
    assign ld_ok     = int'(widx) < NUM_IW + MAX_HIDDEN;
    assign out_free  = !m_tvalid_reg || m_tready;

    always_comb
    begin
        ctrl        = '0;
        ctrl.ni     = ni_c;
        ctrl.nh     = nh_c;
        ctrl.lr     = lr_reg;
        ctrl.delta  = delta_reg;
        ctrl.lrd    = lrd_reg;
        ctrl.ld_val = in_value;
        if (int'(widx) < NUM_IW)
        begin
            ctrl.ld_v = 1'b0;
            ctrl.ld_i = IDX_W'(widx / MAX_HIDDEN);
            ctrl.ld_j = IDX_W'(widx % MAX_HIDDEN);
        end
        else
        begin
            ctrl.ld_v = 1'b1;
            ctrl.ld_j = IDX_W'(widx - 13'(NUM_IW));
        end
        case (state_reg)
            S_IDLE:
            begin
                if (s_acc && s_tuser == KIND_LOAD && ld_ok)
                    ctrl.op = CELL_LOAD;
                else if (s_acc && is_feat && s_tlast)
                    ctrl.op = CELL_CLR;
                else
                    ctrl.op = CELL_NOP;
            end
            S_FWD:  ctrl.op = CELL_MAC;
            S_ACT:  ctrl.op = CELL_ACT;
            S_UPV:  ctrl.op = CELL_UPV;
            S_HERR: ctrl.op = CELL_HERR;
            S_HDEL: ctrl.op = CELL_HDEL;
            S_LRH:  ctrl.op = CELL_LRH;
            S_UPW:  ctrl.op = CELL_UPW;
            default: ctrl.op = CELL_NOP;
        endcase
    end

    // head of the chain: feature stream
    always_comb
    begin
        chain_w[0].xv  = (state_reg == S_FWD || state_reg == S_UPW)
                         && (int'(step_reg) < MAX_INPUTS);
        chain_w[0].idx = IDX_W'(step_reg);
        chain_w[0].x   = buf_reg[step_reg[IW-1:0]];
    end

    for (genvar g = 0; g < MAX_HIDDEN; g++)
    begin : g_cell
        if (g < MAX_HIDDEN - 1)
        begin : g_mid
            mlpt_cell #(.CELL_IDX(g)) u_cell (
                .clk(clk), .rst_n(rst_n), .ctrl(ctrl),
                .chain_in(chain_w[g]), .chain_out(chain_w[g+1]),
                .h(cell_h[g]), .v(cell_v[g]), .sat(cell_sat[g])
            );
        end
        else
        begin : g_end
            mlpt_cell #(.CELL_IDX(g)) u_cell (
                .clk(clk), .rst_n(rst_n), .ctrl(ctrl),
                .chain_in(chain_w[g]), .chain_out(),
                .h(cell_h[g]), .v(cell_v[g]), .sat(cell_sat[g])
            );
        end
    end

    assign osum_prod = 30'($signed({1'b0, cell_h[step_reg[JW-1:0]]}))
                       * 30'(cell_v[step_reg[JW-1:0]]);
    assign o_clip = clip_q(rnd_sh12(48'(acc_reg)));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            lr_reg       <= 16'd6554;
            ni_reg       <= 4'd2;
            nh_reg       <= 4'd2;
            for (int i = 0; i < MAX_INPUTS; i++)
                buf_reg[i] <= '0;
            cnt_reg      <= '0;
            ovr_reg      <= 1'b0;
            step_reg     <= '0;
            osat_reg     <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
            begin
                case (cfg_index)
                    CFG_LR: lr_reg <= cfg_data;
                    CFG_NI: ni_reg <= cfg_data[3:0];
                    CFG_NH: nh_reg <= cfg_data[3:0];
                    default:
                    begin
                    end
                endcase
            end
            // in the final state the result register is reloaded instead
            if (m_tvalid_reg && m_tready && state_reg != S_DONE)
                m_tvalid_reg <= 1'b0;
            case (state_reg)
                S_IDLE:
                begin
                    if (s_acc && is_feat)
                    begin
                        if (CNT_W'(cnt_reg) < ni_c)
                        begin
                            buf_reg[cnt_reg[IW-1:0]] <= in_value;
                            cnt_reg <= cnt_reg + 1'b1;
                        end
                        else
                            ovr_reg <= 1'b1;
                        if (s_tlast)
                        begin
                            train_reg  <= s_tuser == KIND_TRAIN;
                            target_reg <= (in_target > 13'd4096) ? 13'd4096 : in_target;
                            osat_reg   <= 1'b0;
                            step_reg   <= '0;
                            state_reg  <= S_FWD;
                        end
                    end
                end
                S_FWD:
                begin
                    step_reg <= step_reg + 1'b1;
                    if (step_reg == SW'(MAX_INPUTS + MAX_HIDDEN - 1))
                        state_reg <= S_ACT;
                end
                S_ACT:
                begin
                    acc_reg   <= '0;
                    step_reg  <= '0;
                    state_reg <= S_OSUM;
                end
                S_OSUM:
                begin
                    if (CNT_W'(step_reg) < nh_c)
                        acc_reg <= acc_reg + ACC_W'(osum_prod);
                    step_reg <= step_reg + 1'b1;
                    if (step_reg == SW'(MAX_HIDDEN - 1))
                        state_reg <= S_OACT;
                end
                S_OACT:
                begin
                    o_reg <= sigmoid_q($signed(o_clip[15:0]));
                    if (o_clip[16])
                        osat_reg <= 1'b1;
                    state_reg <= train_reg ? S_DERO : S_DONE;
                end
                S_DERO:
                begin
                    dero_reg  <= deriv_q(o_reg);
                    state_reg <= S_DELTA;
                end
                S_DELTA:
                begin
                    delta_reg <= 12'(rnd_sh12(
                                 48'($signed({1'b0, target_reg}) - $signed({1'b0, o_reg}))
                                 * 48'($signed({1'b0, dero_reg}))));
                    state_reg <= S_LRD;
                end
                S_LRD:
                begin
                    lrd_reg   <= 30'($signed({1'b0, lr_reg}) * 30'(delta_reg));
                    state_reg <= S_UPV;
                end
                S_UPV:  state_reg <= S_HERR;
                S_HERR: state_reg <= S_HDEL;
                S_HDEL: state_reg <= S_LRH;
                S_LRH:
                begin
                    step_reg  <= '0;
                    state_reg <= S_UPW;
                end
                S_UPW:
                begin
                    step_reg <= step_reg + 1'b1;
                    if (step_reg == SW'(MAX_INPUTS + MAX_HIDDEN - 1))
                        state_reg <= S_DONE;
                end
                S_DONE:
                begin
                    if (out_free)
                    begin
                        m_tvalid_reg <= 1'b1;
                        m_tdata_reg  <= {ovr_reg, osat_reg | (|cell_sat), train_reg, o_reg};
                        for (int i = 0; i < MAX_INPUTS; i++)
                            buf_reg[i] <= '0;
                        cnt_reg   <= '0;
                        ovr_reg   <= 1'b0;
                        state_reg <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule
`default_nettype wire

FILE: design/mlpt_cell.sv
`default_nettype none
module mlpt_cell #(
    parameter int CELL_IDX = 0
) (
    input  wire                  clk,
    input  wire                  rst_n,
    input  mlpt_pkg::cell_ctrl_t ctrl,
    input  mlpt_pkg::chain_t     chain_in,
    output mlpt_pkg::chain_t     chain_out,
    output logic [12:0]          h,
    output logic signed [15:0]   v,
    output logic                 sat
);
    import mlpt_pkg::*;

    localparam int IW = (MAX_INPUTS > 1) ? $clog2(MAX_INPUTS) : 1;

    logic signed [15:0]      w_reg [MAX_INPUTS];
    logic signed [15:0]      v_reg;
    logic [12:0]             h_reg;
    logic signed [ACC_W-1:0] acc_reg;
    logic signed [16:0]      herr_reg;
    logic [10:0]             dh_reg;
    logic signed [13:0]      hdelta_reg;
    logic signed [31:0]      lrh_reg;
    logic                    sat_reg;
    chain_t                  chain_reg;

    logic                    active;
    logic                    in_ok;
    logic [IW-1:0]           wsel;
    logic signed [31:0]      prod_x;
    logic [16:0]             act_c;
    logic [16:0]             v_new;
    logic [16:0]             w_new;
    logic signed [47:0]      herr_c;
    logic signed [47:0]      hdel_c;
    logic signed [47:0]      lrh_c;

    always_comb
    begin
        active = CNT_W'(CELL_IDX) < ctrl.nh;
        in_ok  = chain_in.xv && (CNT_W'(chain_in.idx) < ctrl.ni);
        wsel   = chain_in.idx[IW-1:0];
        prod_x = 32'(chain_in.x) * 32'(w_reg[wsel]);
        act_c  = clip_q(rnd_sh12(48'(acc_reg)));
        v_new  = clip_q(48'(v_reg)
                 + rnd_sh28(48'(ctrl.lrd) * 48'($signed({1'b0, h_reg}))));
        herr_c = rnd_sh12(48'(ctrl.delta) * 48'(v_reg));
        hdel_c = rnd_sh12(48'(herr_reg) * 48'($signed({1'b0, dh_reg})));
        lrh_c  = 48'($signed({1'b0, ctrl.lr})) * 48'(hdelta_reg);
        w_new  = clip_q(48'(w_reg[wsel])
                 + rnd_sh28(48'(lrh_reg) * 48'(chain_in.x)));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < MAX_INPUTS; i++)
                w_reg[i] <= '0;
            v_reg     <= '0;
            h_reg     <= '0;
            acc_reg   <= '0;
            sat_reg   <= 1'b0;
            chain_reg <= '0;
        end
        else
        begin
            chain_reg <= chain_in;
            case (ctrl.op)
                CELL_CLR:
                begin
                    acc_reg <= '0;
                    sat_reg <= 1'b0;
                end
                CELL_LOAD:
                begin
                    if (ctrl.ld_j == IDX_W'(CELL_IDX))
                    begin
                        if (ctrl.ld_v)
                            v_reg <= ctrl.ld_val;
                        else
                            w_reg[ctrl.ld_i[IW-1:0]] <= ctrl.ld_val;
                    end
                end
                CELL_MAC:
                begin
                    if (active && in_ok)
                        acc_reg <= acc_reg + ACC_W'(prod_x);
                end
                CELL_ACT:
                begin
                    if (active)
                    begin
                        h_reg <= sigmoid_q($signed(act_c[15:0]));
                        if (act_c[16])
                            sat_reg <= 1'b1;
                    end
                end
                CELL_UPV:
                begin
                    if (active)
                    begin
                        v_reg  <= $signed(v_new[15:0]);
                        dh_reg <= deriv_q(h_reg);
                        if (v_new[16])
                            sat_reg <= 1'b1;
                    end
                end
                CELL_HERR: herr_reg   <= 17'(herr_c);
                CELL_HDEL: hdelta_reg <= 14'(hdel_c);
                CELL_LRH:  lrh_reg    <= 32'(lrh_c);
                CELL_UPW:
                begin
                    if (active && in_ok)
                    begin
                        w_reg[wsel] <= $signed(w_new[15:0]);
                        if (w_new[16])
                            sat_reg <= 1'b1;
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    assign chain_out = chain_reg;
    assign h = h_reg;
    assign v = v_reg;
    assign sat = sat_reg;

endmodule
`default_nettype wire

FILE: design/mlpt_checker.sv
`default_nettype none
`include "mlp_one_hidden_layer_trainer_top_macros.svh"
module mlpt_checker (
    input wire        clk,
    input wire        rst_n,
    input wire        s_tvalid,
    input wire        s_tready,
    input wire [1:0]  s_tuser,
    input wire        s_tlast,
    input wire        m_tvalid,
    input wire        m_tready,
    input wire [15:0] m_tdata
);
    import mlpt_pkg::*;

    `MLPT_ASSERT_IMP(a_out_hold, m_tvalid && !m_tready, ##1 m_tvalid, "result dropped while stalled")
    `MLPT_ASSERT_IMP(a_out_stable, m_tvalid && !m_tready, ##1 $stable(m_tdata), "stalled result changed")
    `MLPT_ASSERT_IMP(a_pred_range, m_tvalid, m_tdata[12:0] <= 13'd4096, "prediction above one")
    `MLPT_ASSERT_IMP(a_busy_after_last, s_tvalid && s_tready && s_tlast && (s_tuser == KIND_PRED || s_tuser == KIND_TRAIN), ##1 !s_tready, "input taken during sample work")
endmodule

bind mlp_one_hidden_layer_trainer_top mlpt_checker u_mlpt_checker (.*);
`default_nettype wire

FILE: verif/mlp_one_hidden_layer_trainer_top_tb.sv
`default_nettype none
module mlp_one_hidden_layer_trainer_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import mlpt_pkg::*;

    localparam int N_IN = 8;
    localparam int N_HID = 8;
    localparam int N_INW = N_IN * N_HID;
    localparam logic [1:0] KIND_NONE = 2'd3;
    localparam int CYCLE_LIMIT = 1000000;
    localparam int SETTLE_CYCLES = 150;
    localparam int MAX_GAP = 12;

    typedef struct {
        logic [1:0]  kind;
        logic [15:0] value;
        logic [12:0] target;
        logic [6:0]  widx;
        logic        last;
    } feat_item_t;

    typedef struct {
        logic [12:0] prediction;
        logic        was_training;
        logic        saturated;
        logic        overrun;
    } pred_result_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [39:0] s_tdata = '0;
    logic [1:0]  s_tuser = '0;
    logic        s_tlast = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [15:0] m_tdata;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [1:0]  cfg_index = '0;
    logic [15:0] cfg_data = '0;

    mlp_one_hidden_layer_trainer_top uut (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .s_tuser(s_tuser), .s_tlast(s_tlast),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    // network state mirrored by the predictor
    int          w_in [N_INW];
    int          w_out [N_HID];
    int          hid_act [N_HID];
    int          feat_buf [N_IN];
    int          feat_cnt;
    bit          feat_ovr;
    int unsigned lr_reg;
    int unsigned ni_reg;
    int unsigned nh_reg;

    feat_item_t   item_q [$];
    pred_result_t result_q [$];
    feat_item_t   cur_item;
    int           s_gap = 0;
    int           m_wait = 0;
    int           gap_max = MAX_GAP;
    bit           s_took = 0;
    bit           m_took = 0;
    bit           cfg_done = 0;
    int           err_cnt = 0;
    bit           failed = 0;
    int           cycle_cnt = 0;

    initial begin
        forever #5 clk = ~clk;
    end

    function automatic longint round_sh(longint v, int k);
        return (v + (longint'(1) <<< (k - 1))) >>> k;
    endfunction

    function automatic int sat16(longint v, ref bit flag);
        if (v > 32767)
        begin
            flag = 1;
            return 32767;
        end
        if (v < -32768)
        begin
            flag = 1;
            return -32768;
        end
        return int'(v);
    endfunction

    // piecewise-linear sigmoid at the center of the table cell
    function automatic int sigmoid_plan(int x);
        int cidx;
        int c;
        int a;
        int y;
        cidx = ((x + 32768) * 256) >> 16;
        c = ((2 * cidx + 1) * 32768) / 256 - 32768;
        a = (c < 0) ? -c : c;
        if (a >= 20480)
            y = 4096;
        else if (a >= 9728)
            y = a / 32 + 3456;
        else if (a >= 4096)
            y = a / 8 + 2560;
        else
            y = a / 4 + 2048;
        return (c < 0) ? 4096 - y : y;
    endfunction

    function automatic longint slope_of(int y);
        return (longint'(y) * (4096 - y)) / 4096;
    endfunction

    function automatic int unsigned count_limit(int unsigned v, int unsigned top);
        if (v < 1)
            return 1;
        return (v > top) ? top : v;
    endfunction

    function automatic void clear_weights();
        foreach (w_in[k]) w_in[k] = 0;
        foreach (w_out[k])
        begin
            w_out[k] = 0;
            hid_act[k] = 0;
        end
        foreach (feat_buf[k]) feat_buf[k] = 0;
        feat_cnt = 0;
        feat_ovr = 0;
        lr_reg = 6554;
        ni_reg = 2;
        nh_reg = 2;
    endfunction

    // accepted load or feature; the last runs forward pass and optional gradient step
    function automatic void run_network(feat_item_t it);
        int           v;
        int           ni;
        int           nh;
        int           o;
        int           tgt;
        bit           sat;
        longint       acc;
        longint       delta;
        longint       herr;
        longint       hdel;
        longint       stp;
        pred_result_t r;
        v = int'($signed(it.value));
        sat = 0;
        if (it.kind == KIND_LOAD)
        begin
            if (it.widx < N_INW)
                w_in[it.widx] = v;
            else if (it.widx < N_INW + N_HID)
                w_out[it.widx - N_INW] = v;
            return;
        end
        if (it.kind == KIND_NONE)
            return;
        ni = count_limit(ni_reg, N_IN);
        nh = count_limit(nh_reg, N_HID);
        if (feat_cnt < ni)
        begin
            feat_buf[feat_cnt] = v;
            feat_cnt++;
        end
        else
            feat_ovr = 1;
        if (!it.last)
            return;
        for (int j = 0; j < nh; j++)
        begin
            acc = 0;
            for (int i = 0; i < ni; i++)
                acc += longint'(feat_buf[i]) * w_in[i * N_HID + j];
            hid_act[j] = sigmoid_plan(sat16(round_sh(acc, 12), sat));
        end
        acc = 0;
        for (int j = 0; j < nh; j++)
            acc += longint'(hid_act[j]) * w_out[j];
        o = sigmoid_plan(sat16(round_sh(acc, 12), sat));
        if (it.kind == KIND_TRAIN)
        begin
            tgt = (it.target > 4096) ? 4096 : int'(it.target);
            delta = round_sh(longint'(tgt - o) * slope_of(o), 12);
            for (int j = 0; j < nh; j++)
            begin
                stp = round_sh(longint'(lr_reg) * delta * hid_act[j], 28);
                w_out[j] = sat16(longint'(w_out[j]) + stp, sat);
            end
            for (int j = 0; j < nh; j++)
            begin
                herr = round_sh(delta * w_out[j], 12);
                hdel = round_sh(herr * slope_of(hid_act[j]), 12);
                for (int i = 0; i < ni; i++)
                begin
                    stp = round_sh(longint'(lr_reg) * hdel * feat_buf[i], 28);
                    w_in[i * N_HID + j] = sat16(longint'(w_in[i * N_HID + j]) + stp, sat);
                end
            end
        end
        r.prediction = 13'(o);
        r.was_training = (it.kind == KIND_TRAIN);
        r.saturated = sat;
        r.overrun = feat_ovr;
        result_q.push_back(r);
        foreach (feat_buf[k]) feat_buf[k] = 0;
        feat_cnt = 0;
        feat_ovr = 0;
    endfunction

    // sample at the rising edge: accepted transactions, config writes and result checks
    always @(posedge clk)
    begin
        pred_result_t exp_r;
        s_took = rst_n && s_tvalid && s_tready;
        m_took = rst_n && m_tvalid && m_tready;
        cfg_done = rst_n && cfg_valid && cfg_ready;
        if (s_took)
            run_network(cur_item);
        if (cfg_done)
        begin
            if (cfg_index == CFG_LR)
                lr_reg = cfg_data;
            else if (cfg_index == CFG_NI)
                ni_reg = cfg_data[3:0];
            else if (cfg_index == CFG_NH)
                nh_reg = cfg_data[3:0];
        end
        if (m_took)
        begin
            if (result_q.size() == 0)
            begin
                failed = 1;
                err_cnt++;
                if (err_cnt <= 10)
                    $display("unexpected result %h", m_tdata);
            end
            else
            begin
                exp_r = result_q.pop_front();
                if (m_tdata[12:0] !== exp_r.prediction || m_tdata[13] !== exp_r.was_training
                    || m_tdata[14] !== exp_r.saturated || m_tdata[15] !== exp_r.overrun)
                begin
                    failed = 1;
                    err_cnt++;
                    if (err_cnt <= 10)
                        $display("mismatch: pred %0d/%0d train %b/%b sat %b/%b ovr %b/%b",
                                 exp_r.prediction, m_tdata[12:0], exp_r.was_training,
                                 m_tdata[13], exp_r.saturated, m_tdata[14],
                                 exp_r.overrun, m_tdata[15]);
                end
            end
        end
        cycle_cnt++;
        if (cycle_cnt > CYCLE_LIMIT)
        begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    // feature stream driver
    always @(negedge clk)
    begin
        if (rst_n && (!s_tvalid || s_took))
        begin
            if (s_took)
                s_gap = (gap_max == 0) ? 0 : $urandom_range(0, gap_max);
            if (s_gap > 0)
            begin
                s_gap--;
                s_tvalid <= 1'b0;
            end
            else if (item_q.size() > 0)
            begin
                cur_item = item_q.pop_front();
                s_tdata <= {4'b0, cur_item.widx, cur_item.target, cur_item.value};
                s_tuser <= cur_item.kind;
                s_tlast <= cur_item.last;
                s_tvalid <= 1'b1;
            end
            else
                s_tvalid <= 1'b0;
        end
    end

    // result receiver with random stalls
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (m_took)
                m_wait = (gap_max == 0) ? 0 : $urandom_range(0, gap_max);
            if (m_wait > 0)
            begin
                m_wait--;
                m_tready <= 1'b0;
            end
            else
                m_tready <= 1'b1;
        end
    end

    task automatic push_item(logic [1:0] kind, logic [15:0] value, logic [12:0] target,
                             logic [6:0] widx, logic last);
        feat_item_t it;
        it.kind = kind;
        it.value = value;
        it.target = target;
        it.widx = widx;
        it.last = last;
        item_q.push_back(it);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [15:0] data);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        do @(negedge clk); while (!cfg_done);
        cfg_valid <= 1'b0;
    endtask

    task automatic wait_idle();
        while (item_q.size() > 0 || s_tvalid || result_q.size() > 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    function automatic logic [15:0] rand_value();
        if ($urandom_range(0, 3) == 0)
            return 16'($urandom);
        return 16'($urandom_range(0, 16383) - 8192);
    endfunction

    function automatic logic [12:0] rand_target();
        if ($urandom_range(0, 7) == 0)
            return 13'($urandom);
        return 13'($urandom_range(0, 4096));
    endfunction

    task automatic push_sample(int unsigned n_feat, logic [1:0] mode);
        for (int unsigned f = 0; f < n_feat; f++)
        begin
            if ($urandom_range(0, 19) == 0)
                push_item(KIND_NONE, rand_value(), rand_target(), 7'($urandom), 1'b1);
            push_item((f == n_feat - 1) ? mode : 2'($urandom_range(0, 1)), rand_value(),
                      rand_target(), 7'($urandom), f == n_feat - 1);
        end
    endtask

    initial begin
        int unsigned ni;
        int unsigned nh;
        int unsigned n_feat;
        int          sent;
        clear_weights();
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // extremes, ignored loads, overrun and short samples
        gap_max = 0;
        push_item(KIND_LOAD, 16'h7fff, 13'd0, 7'd0, 1'b0);
        push_item(KIND_LOAD, 16'h8000, 13'h1fff, 7'd1, 1'b1);
        push_item(KIND_LOAD, 16'h7fff, 13'd0, 7'd64, 1'b0);
        push_item(KIND_LOAD, 16'h8000, 13'd0, 7'd65, 1'b0);
        push_item(KIND_LOAD, 16'h0005, 13'd0, 7'd127, 1'b0);
        push_item(KIND_LOAD, 16'h0001, 13'd0, 7'd72, 1'b0);
        push_item(KIND_NONE, 16'hffff, 13'h1fff, 7'h7f, 1'b1);
        push_item(KIND_PRED, 16'h7fff, 13'd0, 7'd0, 1'b0);
        push_item(KIND_PRED, 16'h8000, 13'd0, 7'd0, 1'b1);
        push_item(KIND_PRED, 16'h1000, 13'd0, 7'd0, 1'b0);
        push_item(KIND_TRAIN, 16'h1000, 13'h1fff, 7'd0, 1'b1);
        push_item(KIND_TRAIN, 16'h0800, 13'd0, 7'd0, 1'b0);
        push_item(KIND_TRAIN, 16'hf800, 13'd0, 7'd0, 1'b0);
        push_item(KIND_PRED, 16'h2000, 13'd0, 7'd0, 1'b0);
        push_item(KIND_TRAIN, 16'h3000, 13'd4096, 7'd0, 1'b1);
        push_item(KIND_PRED, 16'h0400, 13'd0, 7'd0, 1'b1);
        push_item(KIND_TRAIN, 16'hc000, 13'd0, 7'd0, 1'b0);
        push_item(KIND_TRAIN, 16'h4000, 13'd0, 7'd0, 1'b1);
        wait_idle();

        for (int p = 1; p <= 12; p++)
        begin
            case (p)
                1: begin write_reg(CFG_LR, 16'd0); write_reg(CFG_NI, 16'd0);
                         write_reg(CFG_NH, 16'd0); end
                2: begin write_reg(CFG_LR, 16'hffff); write_reg(CFG_NI, 16'hffff);
                         write_reg(CFG_NH, 16'h000f); end
                3: begin write_reg(CFG_LR, 16'd6554); write_reg(CFG_NI, 16'd8);
                         write_reg(CFG_NH, 16'd8); end
                default: begin
                    write_reg(CFG_LR, 16'($urandom));
                    write_reg(CFG_NI, 16'($urandom));
                    write_reg(CFG_NH, 16'($urandom));
                end
            endcase
            gap_max = (p % 4 == 0) ? 0 : MAX_GAP;
            ni = count_limit(ni_reg, N_IN);
            nh = count_limit(nh_reg, N_HID);
            sent = 0;
            for (int k = 0; k < 10; k++)
            begin
                push_item(KIND_LOAD, rand_value(), rand_target(),
                          ($urandom_range(0, 9) == 0) ? 7'($urandom)
                                                      : 7'($urandom_range(0, 71)),
                          1'($urandom));
                sent++;
            end
            while (sent < 80)
            begin
                case ($urandom_range(0, 7))
                    0: n_feat = $urandom_range(1, ni);
                    1: n_feat = ni + $urandom_range(1, 3);
                    default: n_feat = ni;
                endcase
                push_sample(n_feat, 2'($urandom_range(0, 1)));
                sent += n_feat;
            end
            wait_idle();
        end

        if (!failed)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end
endmodule
`default_nettype wire
